[rtl/degp_pkg.sv]
// degp_pkg: types, codes and helper functions shared by the delta ID packer
// used by degp_core, degp_rsp_queue, degp_checker and delta_id_exp_golomb_packer
package degp_pkg;

   // field widths
   localparam int ID_W   = 32;
   localparam int IDX_W  = 6;
   localparam int CNT_W  = 10;
   localparam int LEN_W  = 12;
   localparam int CAP_W  = 7;
   localparam int PCNT_W = 5;

   // default and reset values
   localparam int BLOCK_WORDS_DEF = 64;
   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // depth of the result queue
   localparam int RSP_DEPTH = 4;

   // action codes
   localparam logic ACT_APPEND = 1'b0;
   localparam logic ACT_CLOSE  = 1'b1;

   // status codes
   typedef enum logic [1:0] {
      ST_ACCEPTED     = 2'd0,
      ST_DUPLICATE    = 2'd1,
      ST_OUT_OF_ORDER = 2'd2,
      ST_FULL         = 2'd3
   } status_type;

   // one result transaction
   typedef struct packed {
      logic [ID_W-1:0]  packed_word;
      logic             word_valid;
      logic [IDX_W-1:0] word_index;
      status_type       status;
      logic [ID_W-1:0]  first_id;
      logic [CNT_W-1:0] entry_count;
      logic [LEN_W-1:0] bit_length;
      logic             last;
   } rsp_type;

   // results made by one item: always the first, the second only when two words complete
   typedef struct packed {
      logic    two;
      rsp_type first;
      rsp_type second;
   } enc_out_type;

   // bit length of a 33-bit value (position of leading one plus one)
   function automatic logic [5:0] bit_len(input logic [32:0] value);
      logic [5:0] len;
      len = 6'd0;
      for (int i = 0; i < 33; i++) begin
         if (value[i]) begin
            len = 6'(i + 1);
         end
      end
      return len;
   endfunction

endpackage

[rtl/delta_id_exp_golomb_packer.sv]
// delta_id_exp_golomb_packer: top level of the delta row id exp-golomb packer
// depends on degp_pkg, degp_core and degp_rsp_queue
//
//   channel  | direction | handshake            | payload
//   req      | in        | req_valid/req_stall  | action, row_id
//   rsp      | out       | rsp_valid/rsp_stall  | word, status and block report
//   csr      | in        | csr_wr_en            | capacity_words
//
// an item is registered on acceptance and coded once the result queue has
// room; its results are written to the result queue and can be taken from there.
// one item per cycle is taken while the queue has room; two completed words
// make two transactions, so the result port sets the rate at one a cycle.
// synchronous reset clears the block and sets capacity to 64 words.
// rsp_stall backs up into the four-entry result queue and then into req_stall.
module delta_id_exp_golomb_packer #(
   parameter int BLOCK_WORDS = degp_pkg::BLOCK_WORDS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_action,
   input  logic [degp_pkg::ID_W-1:0]   req_row_id,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [degp_pkg::ID_W-1:0]   rsp_packed_word,
   output logic                        rsp_word_valid,
   output logic [degp_pkg::IDX_W-1:0]  rsp_word_index,
   output logic [1:0]                  rsp_status,
   output logic [degp_pkg::ID_W-1:0]   rsp_first_id,
   output logic [degp_pkg::CNT_W-1:0]  rsp_entry_count,
   output logic [degp_pkg::LEN_W-1:0]  rsp_bit_length,
   output logic                        rsp_last,
   input  logic                        csr_wr_en,
   input  logic [degp_pkg::CAP_W-1:0]  csr_wr_data
);

   logic                         in_valid_ff, in_valid_in;
   logic                         in_action_ff;
   logic [degp_pkg::ID_W-1:0]    in_row_id_ff;
   logic [degp_pkg::CAP_W-1:0]   capacity_ff;
   logic                         fire;
   logic                         req_take;
   logic                         has_room;
   degp_pkg::enc_out_type        enc_out;
   degp_pkg::rsp_type            head_data;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= degp_pkg::CAP_RESET;
      end else if (csr_wr_en) begin
         capacity_ff <= csr_wr_data;
      end
   end

   // input register, refilled in the cycle it is coded
   assign fire      = in_valid_ff && has_room;
   assign req_stall = in_valid_ff && !fire;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_action_ff <= req_action;
         in_row_id_ff <= req_row_id;
      end
   end

   // coder and block state
   degp_core #(
      .BLOCK_WORDS (BLOCK_WORDS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .item_action (in_action_ff),
      .item_row_id (in_row_id_ff),
      .capacity    (capacity_ff),
      .enc_out     (enc_out)
   );

   // result queue
   degp_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fire),
      .push_data (enc_out),
      .pop       (rsp_valid && !rsp_stall),
      .has_room  (has_room),
      .not_empty (rsp_valid),
      .head_data (head_data)
   );

   // result payload
   assign rsp_packed_word = head_data.packed_word;
   assign rsp_word_valid  = head_data.word_valid;
   assign rsp_word_index  = head_data.word_index;
   assign rsp_status      = head_data.status;
   assign rsp_first_id    = head_data.first_id;
   assign rsp_entry_count = head_data.entry_count;
   assign rsp_bit_length  = head_data.bit_length;
   assign rsp_last        = head_data.last;

endmodule

[rtl/degp_core.sv]
// degp_core: block state and the single-pass exp-golomb coder and word packer
// depends on degp_pkg
module degp_core #(
   parameter int BLOCK_WORDS = degp_pkg::BLOCK_WORDS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fire,
   input  logic                         item_action,
   input  logic [degp_pkg::ID_W-1:0]    item_row_id,
   input  logic [degp_pkg::CAP_W-1:0]   capacity,
   output degp_pkg::enc_out_type        enc_out
);

   localparam int CAP_W = degp_pkg::CAP_W;

   // block state
   logic                          have_first_ff, have_first_in;
   logic [degp_pkg::ID_W-1:0]     first_id_ff, first_id_in;
   logic [degp_pkg::ID_W-1:0]     previous_id_ff, previous_id_in;
   logic [degp_pkg::LEN_W-1:0]    bits_used_ff, bits_used_in;
   logic [degp_pkg::ID_W-1:0]     pending_bits_ff, pending_bits_in;
   logic [degp_pkg::PCNT_W-1:0]   pending_count_ff, pending_count_in;
   logic [degp_pkg::IDX_W-1:0]    next_word_index_ff, next_word_index_in;
   logic [degp_pkg::CNT_W-1:0]    ids_held_ff, ids_held_in;

   // coder datapath
   logic [32:0]                   delta;
   logic [32:0]                   code_val;
   logic [5:0]                    code_bits;
   logic [6:0]                    code_len;
   logic [6:0]                    total;
   logic [95:0]                   stream;
   logic [95:0]                   stream_tail;
   logic [31:0]                   rem_mask;
   logic [degp_pkg::CAP_W-1:0]    cap_eff;
   logic [12:0]                   cap_bits;
   logic [12:0]                   need_bits;
   logic                          fits;
   logic [1:0]                    nwords;

   always_ff @(posedge clock) begin
      if (reset) begin
         have_first_ff      <= 1'b0;
         first_id_ff        <= '0;
         previous_id_ff     <= '0;
         bits_used_ff       <= '0;
         pending_bits_ff    <= '0;
         pending_count_ff   <= '0;
         next_word_index_ff <= '0;
         ids_held_ff        <= '0;
      end else if (fire) begin
         have_first_ff      <= have_first_in;
         first_id_ff        <= first_id_in;
         previous_id_ff     <= previous_id_in;
         bits_used_ff       <= bits_used_in;
         pending_bits_ff    <= pending_bits_in;
         pending_count_ff   <= pending_count_in;
         next_word_index_ff <= next_word_index_in;
         ids_held_ff        <= ids_held_in;
      end
   end

   // code: v = delta + 7 written in 2p+4 bits, leading zeros come for free
   always_comb begin
      delta     = {1'b0, item_row_id} - {1'b0, previous_id_ff};
      code_val  = delta + 33'd7;
      code_bits = degp_pkg::bit_len(code_val);
      code_len  = {code_bits, 1'b0} - 7'd4;
      total     = 7'(pending_count_ff) + code_len;
      nwords    = total[6:5];
      // pending bits then code, left aligned in a 96-bit window
      stream      = (96'(pending_bits_ff) << (7'd96 - 7'(pending_count_ff)))
                  | (96'(code_val) << (7'd96 - total));
      stream_tail = stream >> (7'd96 - total);
      rem_mask    = ~(32'hffff_ffff << total[4:0]);
   end

   // capacity check against the saturated word count
   always_comb begin
      cap_eff   = (32'(capacity) > BLOCK_WORDS) ? CAP_W'(BLOCK_WORDS) : capacity;
      cap_bits  = 13'(cap_eff) << 5;
      need_bits = 13'(bits_used_ff) + 13'(code_len);
      fits      = need_bits <= cap_bits;
   end

   // next state and result transactions
   always_comb begin
      have_first_in      = have_first_ff;
      first_id_in        = first_id_ff;
      previous_id_in     = previous_id_ff;
      bits_used_in       = bits_used_ff;
      pending_bits_in    = pending_bits_ff;
      pending_count_in   = pending_count_ff;
      next_word_index_in = next_word_index_ff;
      ids_held_in        = ids_held_ff;

      enc_out                    = '0;
      enc_out.first.status       = degp_pkg::ST_ACCEPTED;
      enc_out.second.status      = degp_pkg::ST_ACCEPTED;

      priority if (item_action == degp_pkg::ACT_CLOSE) begin
         // flush partial word, then clear the block
         if (pending_count_ff != '0) begin
            enc_out.first.packed_word = pending_bits_ff << (6'd32 - 6'(pending_count_ff));
            enc_out.first.word_valid  = 1'b1;
            enc_out.first.word_index  = next_word_index_ff;
         end
         have_first_in      = 1'b0;
         first_id_in        = '0;
         previous_id_in     = '0;
         bits_used_in       = '0;
         pending_bits_in    = '0;
         pending_count_in   = '0;
         next_word_index_in = '0;
         ids_held_in        = '0;
      end else if (!have_first_ff) begin
         // first id of the block is kept raw
         have_first_in  = 1'b1;
         first_id_in    = item_row_id;
         previous_id_in = item_row_id;
         ids_held_in    = 10'd1;
      end else if (item_row_id == previous_id_ff) begin
         enc_out.first.status = degp_pkg::ST_DUPLICATE;
      end else if (item_row_id < previous_id_ff) begin
         enc_out.first.status = degp_pkg::ST_OUT_OF_ORDER;
      end else if (!fits) begin
         enc_out.first.status = degp_pkg::ST_FULL;
      end else begin
         // append the code and emit the words it completes
         pending_bits_in    = stream_tail[31:0] & rem_mask;
         pending_count_in   = total[4:0];
         bits_used_in       = bits_used_ff + 12'(code_len);
         ids_held_in        = ids_held_ff + 10'd1;
         previous_id_in     = item_row_id;
         next_word_index_in = next_word_index_ff + 6'(nwords);
         if (nwords != 2'd0) begin
            enc_out.first.packed_word = stream[95:64];
            enc_out.first.word_valid  = 1'b1;
            enc_out.first.word_index  = next_word_index_ff;
         end
         if (nwords == 2'd2) begin
            enc_out.two                = 1'b1;
            enc_out.second.packed_word = stream[63:32];
            enc_out.second.word_valid  = 1'b1;
            enc_out.second.word_index  = next_word_index_ff + 6'd1;
         end
      end

      // block report: before clearing on close, after the update otherwise
      if (item_action == degp_pkg::ACT_CLOSE) begin
         enc_out.first.first_id    = first_id_ff;
         enc_out.first.entry_count = ids_held_ff;
         enc_out.first.bit_length  = bits_used_ff;
      end else begin
         enc_out.first.first_id    = first_id_in;
         enc_out.first.entry_count = ids_held_in;
         enc_out.first.bit_length  = bits_used_in;
      end
      enc_out.second.first_id    = first_id_in;
      enc_out.second.entry_count = ids_held_in;
      enc_out.second.bit_length  = bits_used_in;
      enc_out.first.last         = !enc_out.two;
      enc_out.second.last        = 1'b1;
   end

endmodule

[rtl/degp_rsp_queue.sv]
// degp_rsp_queue: small result queue that takes one or two transactions a cycle
// and hands one a cycle to the result channel; depends on degp_pkg
module degp_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  degp_pkg::enc_out_type push_data,
   input  logic                  pop,
   output logic                  has_room,
   output logic                  not_empty,
   output degp_pkg::rsp_type     head_data
);

   localparam int PTR_W = $clog2(degp_pkg::RSP_DEPTH);
   localparam int CNT_W = $clog2(degp_pkg::RSP_DEPTH + 1);

   degp_pkg::rsp_type   entry_ff [degp_pkg::RSP_DEPTH];
   logic [PTR_W-1:0]    head_ff, head_in;
   logic [PTR_W-1:0]    tail_ff, tail_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    push_n;
   logic [PTR_W-1:0]    tail_next;

   // room for the worst case of two transactions
   assign has_room  = count_ff <= CNT_W'(degp_pkg::RSP_DEPTH - 2);
   assign not_empty = count_ff != '0;
   assign head_data = entry_ff[head_ff];

   // pointer and fill bookkeeping
   always_comb begin
      push_n    = push ? (push_data.two ? CNT_W'(2) : CNT_W'(1)) : '0;
      tail_next = tail_ff + PTR_W'(1);
      tail_in   = tail_ff + PTR_W'(push_n);
      head_in   = pop ? head_ff + PTR_W'(1) : head_ff;
      count_in  = count_ff + push_n - (pop ? CNT_W'(1) : CNT_W'(0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_data.first;
         if (push_data.two) begin
            entry_ff[tail_next] <= push_data.second;
         end
      end
   end

endmodule

[rtl/degp_checker.sv]
// degp_checker: port-level assertions for the delta id packer, bound to the top
// depends on degp_pkg and delta_id_exp_golomb_packer
module degp_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [degp_pkg::ID_W-1:0]   rsp_packed_word,
   input logic                        rsp_word_valid,
   input logic [degp_pkg::IDX_W-1:0]  rsp_word_index,
   input logic [1:0]                  rsp_status,
   input logic [degp_pkg::CNT_W-1:0]  rsp_entry_count,
   input logic [degp_pkg::LEN_W-1:0]  rsp_bit_length,
   input logic                        rsp_last
);

   // a transaction without a word carries zero word and index
   a_no_word_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word_valid |-> rsp_packed_word == '0 && rsp_word_index == '0)
      else $error("word fields not zero on a transaction without a word");

   // a rejected or ignored item gives exactly one transaction and no word
   a_reject_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != degp_pkg::ST_ACCEPTED |-> !rsp_word_valid && rsp_last)
      else $error("rejected item produced a word or a second transaction");

   // an empty block has used no code bits and emits no word
   a_empty_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entry_count == '0 |-> rsp_bit_length == '0 && !rsp_word_valid)
      else $error("empty block reports code bits or a word");

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_packed_word)
         && $stable(rsp_last) && $stable(rsp_word_index))
      else $error("stalled result transaction changed");

   // input is held off only while results are waiting
   a_req_stall_backlog: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |-> rsp_valid)
      else $error("input stalled with no result waiting");

endmodule

bind delta_id_exp_golomb_packer degp_checker u_degp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_packed_word (rsp_packed_word),
   .rsp_word_valid  (rsp_word_valid),
   .rsp_word_index  (rsp_word_index),
   .rsp_status      (rsp_status),
   .rsp_entry_count (rsp_entry_count),
   .rsp_bit_length  (rsp_bit_length),
   .rsp_last        (rsp_last)
);
